/* rtl/dvc_pkg.sv */
// Shared types, constants and helpers for the distinct value counter.
// Used by dvc_cell, dvc_tally and distinct_value_counter_unit; no dependencies.
`default_nettype none

package dvc_pkg;

   localparam int CAPACITY   = 1024;
   localparam int VALUE_W    = 64;
   localparam int COUNT_W    = 11;
   localparam int BYTES_W    = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 2;

   localparam logic [CSR_ADDR_W-1:0] REG_ITEM_BYTES   = 2'd0;
   localparam logic [BYTES_W-1:0]    ITEM_BYTES_RESET = 4'd8;

   typedef enum logic [0:0] {
      OP_ADD   = 1'b0,
      OP_CLEAR = 1'b1
   } op_type;

   typedef struct packed {
      op_type               operation;
      logic [VALUE_W-1:0]   value;
      logic                 value_is_null;
   } req_word_type;

   typedef struct packed {
      logic [COUNT_W-1:0]   distinct_count;
      logic                 was_new;
      logic                 overflow;
   } rsp_word_type;

   // search token handed from cell to cell
   typedef struct packed {
      logic                 valid;
      logic                 clear;
      logic                 is_null;
      logic [VALUE_W-1:0]   key;
      logic                 found;
      logic                 placed;
   } token_type;

   // byte mask for the configured width; 0 acts as 1, above 8 acts as 8
   function automatic logic [VALUE_W-1:0] width_mask(input logic [BYTES_W-1:0] bytes);
      logic [BYTES_W-1:0] eff;
      logic [VALUE_W-1:0] m;
      if (bytes == 4'd0) begin
         eff = 4'd1;
      end else if (bytes > 4'd8) begin
         eff = 4'd8;
      end else begin
         eff = bytes;
      end
      for (int i = 0; i < 8; i++) begin
         m[8*i +: 8] = (BYTES_W'(i) < eff) ? 8'hFF : 8'h00;
      end
      return m;
   endfunction

endpackage

`default_nettype wire

/* rtl/dvc_cell.sv */
// One storage cell of the set: holds one entry and its in-use flag, compares
// the passing token and claims it when it is the first free cell. Uses dvc_pkg.
`default_nettype none

module dvc_cell (
   input  wire                 clock,
   input  wire                 reset,
   input  dvc_pkg::token_type  tok_in,
   output dvc_pkg::token_type  tok_out
);

   logic [dvc_pkg::VALUE_W-1:0] entry_ff;
   logic [dvc_pkg::VALUE_W-1:0] entry_in;
   logic                        used_ff;
   logic                        used_in;
   dvc_pkg::token_type          tok_ff;
   dvc_pkg::token_type          tok_in_next;

   always_comb begin
      used_in     = used_ff;
      entry_in    = entry_ff;
      tok_in_next = tok_in;
      if (tok_in.valid) begin
         if (tok_in.clear) begin
            used_in = 1'b0;
         end else if (!tok_in.is_null) begin
            if (used_ff) begin
               if (entry_ff == tok_in.key) begin
                  tok_in_next.found = 1'b1;
               end
            end else if (!tok_in.found && !tok_in.placed) begin
               used_in            = 1'b1;
               entry_in           = tok_in.key;
               tok_in_next.placed = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
         tok_ff  <= '0;
      end else begin
         used_ff <= used_in;
         tok_ff  <= tok_in_next;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign tok_out = tok_ff;

endmodule

`default_nettype wire

/* rtl/dvc_tally.sv */
// Result stage: takes tokens leaving the cell row in order, keeps the
// distinct count and overflow flag, drives the result word. Uses dvc_pkg.
`default_nettype none

module dvc_tally #(
   parameter int CAPACITY = dvc_pkg::CAPACITY
) (
   input  wire                   clock,
   input  wire                   reset,
   input  dvc_pkg::token_type    tok_in,
   output logic                  rsp_strobe,
   output dvc_pkg::rsp_word_type rsp_word
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int OUT_W = dvc_pkg::COUNT_W;

   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic                  ovf_ff;
   logic                  ovf_in;
   logic                  was_new;
   logic                  strobe_ff;
   dvc_pkg::rsp_word_type word_ff;
   dvc_pkg::rsp_word_type word_in;

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      was_new  = 1'b0;
      if (tok_in.valid) begin
         if (tok_in.clear) begin
            count_in = '0;
            ovf_in   = 1'b0;
         end else if (!tok_in.is_null) begin
            if (tok_in.placed) begin
               count_in = count_ff + CNT_W'(1);
               was_new  = 1'b1;
            end else if (!tok_in.found) begin
               ovf_in = 1'b1;
            end
         end
      end
      word_in.distinct_count = OUT_W'(count_in);
      word_in.was_new        = was_new;
      word_in.overflow       = ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         ovf_ff    <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         ovf_ff    <= ovf_in;
         strobe_ff <= tok_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_word   = word_ff;

endmodule

`default_nettype wire

/* rtl/distinct_value_counter_unit.sv */
// Top level of the distinct value counter: register port, word launch and the
// row of dvc_cell instances feeding dvc_tally. Uses dvc_pkg.
//
//   channel   ports                          direction  handshake
//   request   start, busy, req_word          in         start & !busy
//   result    rsp_strobe, rsp_word           out        strobe, one cycle
//   config    csr_psel .. csr_pready         in/out     APB, pready tied high
//
// A word is taken in every cycle; busy stays low. Each word walks the row of
// CAPACITY cells, one cell per cycle, through the launch register, each cell's
// token register and the tally's result register; results leave in request order.
// Reset is synchronous and empties the set (in-use flags cleared, count zero).
// The receiver cannot stall; nothing inside ever waits.
`default_nettype none

module distinct_value_counter_unit #(
   parameter int CAPACITY = dvc_pkg::CAPACITY
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                start,
   output logic                               busy,
   input  dvc_pkg::req_word_type              req_word,
   output logic                               rsp_strobe,
   output dvc_pkg::rsp_word_type              rsp_word,
   input  wire                                csr_psel,
   input  wire                                csr_penable,
   input  wire                                csr_pwrite,
   input  wire  [dvc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire  [dvc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [dvc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   localparam int BW = dvc_pkg::BYTES_W;
   localparam int DW = dvc_pkg::CSR_DATA_W;

   logic [BW-1:0]      item_bytes_ff;
   logic [BW-1:0]      item_bytes_in;
   logic               csr_write;
   logic               accept;
   dvc_pkg::token_type launch_ff;
   dvc_pkg::token_type launch_in;
   dvc_pkg::token_type chain_w [CAPACITY+1];

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      item_bytes_in = item_bytes_ff;
      if (csr_write && (csr_paddr == dvc_pkg::REG_ITEM_BYTES)) begin
         item_bytes_in = csr_pwdata[BW-1:0];
      end
   end

   always_comb begin
      case (csr_paddr)
         dvc_pkg::REG_ITEM_BYTES: csr_prdata = {{(DW-BW){1'b0}}, item_bytes_ff};
         default:                 csr_prdata = '0;
      endcase
   end

   // word launch
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   always_comb begin
      launch_in.valid   = accept;
      launch_in.clear   = (req_word.operation == dvc_pkg::OP_CLEAR);
      launch_in.is_null = req_word.value_is_null;
      launch_in.key     = req_word.value & dvc_pkg::width_mask(item_bytes_ff);
      launch_in.found   = 1'b0;
      launch_in.placed  = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_bytes_ff <= dvc_pkg::ITEM_BYTES_RESET;
         launch_ff     <= '0;
      end else begin
         item_bytes_ff <= item_bytes_in;
         launch_ff     <= launch_in;
      end
   end

   // cell row
   assign chain_w[0] = launch_ff;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      dvc_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .tok_in  (chain_w[g]),
         .tok_out (chain_w[g+1])
      );
   end

   dvc_tally #(
      .CAPACITY (CAPACITY)
   ) u_tally (
      .clock      (clock),
      .reset      (reset),
      .tok_in     (chain_w[CAPACITY]),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

endmodule

`default_nettype wire
